// File: rtl/core/atoi_pkg.sv
// ----------------------------------------------------------------------------
// atoi_pkg: shared types and constants for the ASCII to integer parser
// Parser phases, status codes, character constants and the digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package atoi_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int VALUE_BITS      = 64;
    localparam int RADIX_BITS      = 6;
    localparam int END_BITS        = 16;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_BITS-1:0] NO_DIGIT    = 6'd36;
    localparam logic [RADIX_BITS-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_BITS-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_BITS-1:0] BASE_HEX    = 6'd16;
    localparam logic [7:0]            CASE_FOLD   = 8'd32;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;

    typedef enum logic [0:0] {
        CFG_RADIX = 1'b0,
        CFG_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_SPACE   = 3'd0,
        PH_START   = 3'd1,
        PH_ZERO    = 3'd2,
        PH_HEXPFX  = 3'd3,
        PH_DIGITS  = 3'd4,
        PH_DONE    = 3'd5,
        PH_INVALID = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_BAD_BASE = 2'd2
    } status_t;

    // Digit value of a character in base 36, NO_DIGIT when it is none.
    function automatic logic [RADIX_BITS-1:0] digit_of(input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c >= 8'h41 && c <= 8'h5A) f = c + CASE_FOLD;
        if (f >= 8'h30 && f <= 8'h39) return RADIX_BITS'(f - 8'h30);
        if (f >= 8'h61 && f <= 8'h7A) return RADIX_BITS'(f - 8'h61 + 8'd10);
        return NO_DIGIT;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ascii_to_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_to_integer_parser: streaming strtoul-style string to integer converter
// Takes one byte per request, emits value, status and end offset on NUL.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  input   | in        | in_valid / in_stall   | char_in[7:0]
//  output  | out       | out_valid / out_stall | value[63:0] status end_offset
//  config  | in        | cfg_valid / cfg_ready | cfg_index, cfg_data[63:0]
//
//  One byte per cycle sustained while no NUL is held back: a byte is held in
//  the input register, then one pass through the digit multiply-add (64x6
//  bits) and the limit compare updates the string state; a NUL loads the
//  result register from there. Reset (rst_n, async low) clears all control
//  state, radix to 10, limit_reg to all ones. out_stall only holds back NUL
//  bytes while a result is still waiting; other bytes keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_to_integer_parser #(
    parameter int OFFSET_BITS = atoi_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input byte channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      char_in,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [atoi_pkg::VALUE_BITS-1:0]      value,
    output logic [1:0]                           status,
    output logic [atoi_pkg::END_BITS-1:0]        end_offset,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [atoi_pkg::VALUE_BITS-1:0] cfg_data
);

    import atoi_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam int PROD_BITS = VALUE_BITS + RADIX_BITS;

    // configuration registers
    logic [RADIX_BITS-1:0] radix_reg;
    logic [VALUE_BITS-1:0] limit_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;

    // string state
    phase_t                phase_reg, phase_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [RADIX_BITS-1:0] base_reg, base_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS:0]   stop_reg, stop_next;   // one wider: saturated pos + 1
    logic                  conv_reg, conv_next;
    logic                  ovf_reg, ovf_next;

    // result register
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    status_t               status_reg, status_next;
    logic [END_BITS-1:0]   end_reg, end_next;

    logic accept;
    logic advance;
    logic out_free;
    logic is_nul;
    logic radix_ok;
    logic radix_auto_hex;          // radix is 0 or 16: 0x prefix allowed
    logic [RADIX_BITS-1:0] take_base;
    logic [RADIX_BITS-1:0] digit;
    logic [PROD_BITS-1:0]  prod;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [END_BITS-1:0]   stop_trim;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            limit_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIX: radix_reg <= cfg_data[RADIX_BITS-1:0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Handshake: a NUL byte needs a free result slot, other bytes always pass.
    assign is_nul   = (char_reg == CHAR_NUL);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!is_nul || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_in;
        end
    end

    assign radix_ok       = (radix_reg == '0) || (radix_reg >= 6'd2 && radix_reg <= RADIX_MAX);
    assign radix_auto_hex = (radix_reg == '0) || (radix_reg == BASE_HEX);

    // Base used by the digit path: the first digit of a string uses the
    // radix register directly, later digits the latched base.
    always_comb
    begin
        if (phase_reg == PH_SPACE || phase_reg == PH_START)
        begin
            take_base = (radix_reg == '0) ? BASE_DEC : radix_reg;
        end
        else
        begin
            take_base = base_reg;
        end
    end

    assign digit = digit_of(char_reg);

    // acc*base + d > limit is the same test as the limit/base, limit%base
    // comparison, without needing a divider.
    assign prod    = PROD_BITS'(acc_reg) * PROD_BITS'(take_base) + PROD_BITS'(digit);
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    generate
        if (OFFSET_BITS + 1 >= END_BITS)
        begin : g_trim
            assign stop_trim = stop_reg[END_BITS-1:0];
        end
        else
        begin : g_pad
            assign stop_trim = {{(END_BITS-OFFSET_BITS-1){1'b0}}, stop_reg};
        end
    endgenerate

    always_comb
    begin
        logic do_digit;
        logic start_byte;

        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        pos_next    = pos_reg;
        stop_next   = stop_reg;
        conv_next   = conv_reg;
        ovf_next    = ovf_reg;
        value_next  = value_reg;
        status_next = status_reg;
        end_next    = end_reg;
        do_digit    = 1'b0;
        start_byte  = 1'b0;

        if (is_nul)
        begin
            if (phase_reg == PH_INVALID ||
                ((phase_reg == PH_SPACE || phase_reg == PH_START) && !radix_ok))
            begin
                value_next  = '0;
                status_next = ST_BAD_BASE;
                end_next    = '0;
            end
            else
            begin
                value_next  = neg_reg ? ('0 - acc_reg) : acc_reg;
                status_next = ovf_reg ? ST_RANGE : ST_OK;
                end_next    = conv_reg ? stop_trim : '0;
            end
            phase_next = PH_SPACE;
            acc_next   = '0;
            neg_next   = 1'b0;
            base_next  = '0;
            pos_next   = '0;
            stop_next  = '0;
            conv_next  = 1'b0;
            ovf_next   = 1'b0;
        end
        else
        begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_SPACE:
                begin
                    if (char_reg inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF})
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (char_reg inside {CHAR_PLUS, CHAR_MINUS})
                    begin
                        if (!radix_ok)
                        begin
                            phase_next = PH_INVALID;
                        end
                        else
                        begin
                            neg_next   = (char_reg == CHAR_MINUS);
                            phase_next = PH_START;
                        end
                    end
                    else
                    begin
                        start_byte = 1'b1;
                    end
                end
                PH_START:
                begin
                    start_byte = 1'b1;
                end
                PH_ZERO:
                begin
                    if ((char_reg == CHAR_X_LO || char_reg == CHAR_X_UP) && radix_auto_hex)
                    begin
                        base_next  = BASE_HEX;
                        phase_next = PH_HEXPFX;
                    end
                    else
                    begin
                        do_digit = 1'b1;
                    end
                end
                PH_HEXPFX, PH_DIGITS:
                begin
                    do_digit = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // first byte after whitespace and sign: latch the base
            if (start_byte)
            begin
                if (!radix_ok)
                begin
                    phase_next = PH_INVALID;
                end
                else if (char_reg == CHAR_ZERO && radix_auto_hex)
                begin
                    // lone zero counts as a converted digit
                    base_next  = (radix_reg == '0) ? BASE_OCT : BASE_HEX;
                    acc_next   = '0;
                    conv_next  = 1'b1;
                    stop_next  = {1'b0, pos_reg} + 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_next = take_base;
                    do_digit  = 1'b1;
                end
            end

            if (do_digit)
            begin
                if (take_base < 6'd2 || digit >= take_base)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    stop_next = {1'b0, pos_reg} + 1'b1;
                    conv_next = 1'b1;
                    if (prod > PROD_BITS'(limit_reg))
                    begin
                        acc_next   = '1;
                        neg_next   = 1'b0;
                        ovf_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        acc_next   = prod[VALUE_BITS-1:0];
                        phase_next = PH_DIGITS;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            pos_reg   <= '0;
            stop_reg  <= '0;
            conv_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            pos_reg   <= pos_next;
            stop_reg  <= stop_next;
            conv_reg  <= conv_next;
            ovf_reg   <= ovf_next;
        end
    end

    // result register: loaded on NUL, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_nul)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_nul)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            end_reg    <= end_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign status     = status_reg;
    assign end_offset = end_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_BAD_BASE) |-> (value == '0 && end_offset == '0))
        else $error("invalid base result carries data");

    a_range_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_RANGE) |-> (value == '1))
        else $error("range overflow result is not all ones");

    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_INVALID) |-> (acc_reg == '0 && !conv_reg && !ovf_reg))
        else $error("invalid phase holds conversion state");

    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(char_reg)))
        else $error("stalled input byte lost");

    a_nul_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_nul) |=> (phase_reg == PH_SPACE && out_valid_reg))
        else $error("parser did not rearm after NUL");

endmodule

`default_nettype wire

// File: test/ascii_to_integer_parser_test.sv
// ----------------------------------------------------------------------------
// ascii_to_integer_parser_test: self-checking bench for the string parser
// Streams NUL-terminated strings into the parser and checks each result
// against an in-bench model of the parse or a typed result, across radix and limit settings.
// ----------------------------------------------------------------------------
module ascii_to_integer_parser_test;

    import atoi_pkg::*;

    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          QUIET_LIMIT = 3000;  // cycles with no transfer at all
    localparam int          LONG_HOLD   = 300;   // receiver back-pressure stretch
    localparam int          SETTLE_WAIT = 4;     // idle margin after the last result
    localparam int          PHASE_BYTES = 95;    // minimum random bytes per setting
    localparam int          NUM_PHASES  = 10;
    localparam int          NUM_PROBES  = 10;
    localparam int          LONG_ZEROS  = 30;    // long run of leading zeros

    // One result of the parser.
    typedef struct packed {
        logic [63:0] value;
        status_t     status;
        logic [15:0] end_offset;
    } conversion_t;

    // Directed row: settings, text (NUL appended), and optional typed result.
    typedef struct {
        logic [5:0]  radix;
        logic [63:0] limit;
        string       text;
        bit          typed;
        conversion_t result;
    } probe_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic [1:0]  status;
    logic [15:0] end_offset;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [63:0] cfg_data;

    ascii_to_integer_parser i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .status     (status),
        .end_offset (end_offset),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    conversion_t conversions_due [$];   // results still owed by the parser
    conversion_t typed_result;          // hand-written result for a directed row
    bit          typed_pending;
    conversion_t due;
    int          mismatches;
    int          quiet_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_req;
    logic [7:0]  text_buf [$];

    // Register copies as the parser should hold them.
    logic [5:0]  cur_radix;
    logic [63:0] cur_limit;

    // String state of the model parse.
    phase_t      p_phase;
    logic [63:0] p_acc;
    bit          p_neg;
    logic [5:0]  p_base;
    logic [15:0] p_pos;
    logic [16:0] p_stop;   // one wider: pos + 1 may wrap the 16-bit field
    bit          p_conv;
    bit          p_ovf;

    // ------------------------------------------------------------------------
    // Model of the parse
    // ------------------------------------------------------------------------
    function automatic logic [5:0] char_digit(input logic [7:0] c);
        logic [7:0] l;
        l = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;   // fold A..Z
        if (l >= 8'h30 && l <= 8'h39)
        begin
            return 6'(l - 8'h30);
        end
        if (l >= 8'h61 && l <= 8'h7A)
        begin
            return 6'(l - 8'h61 + 8'd10);
        end
        return NO_DIGIT;
    endfunction

    function automatic bit radix_usable();
        return cur_radix == 6'd0 || (cur_radix >= 6'd2 && cur_radix <= RADIX_MAX);
    endfunction

    task automatic clear_string();
        p_phase = PH_SPACE;
        p_acc   = '0;
        p_neg   = 1'b0;
        p_base  = '0;
        p_pos   = '0;
        p_stop  = '0;
        p_conv  = 1'b0;
        p_ovf   = 1'b0;
    endtask

    // One digit candidate in the latched base; overflow pins value to all ones.
    task automatic take_digit(input logic [7:0] c);
        logic [5:0]  d;
        logic [63:0] b;
        logic [63:0] quot;
        logic [63:0] rem;
        d = char_digit(c);
        b = 64'(p_base);
        if (p_base < 6'd2 || d >= p_base)
        begin
            p_phase = PH_DONE;
            return;
        end
        quot   = cur_limit / b;
        rem    = cur_limit % b;
        p_stop = 17'(p_pos) + 17'd1;
        p_conv = 1'b1;
        if (p_acc > quot || (p_acc == quot && 64'(d) > rem))
        begin
            p_acc   = ALL_ONES;
            p_neg   = 1'b0;
            p_ovf   = 1'b1;
            p_phase = PH_DONE;
            return;
        end
        p_acc   = p_acc * b + 64'(d);
        p_phase = PH_DIGITS;
    endtask

    // First byte past whitespace and sign: latch the base, catch a leading 0.
    task automatic begin_number(input logic [7:0] c);
        if (!radix_usable())
        begin
            p_phase = PH_INVALID;
            return;
        end
        if (c == CHAR_ZERO && (cur_radix == 6'd0 || cur_radix == BASE_HEX))
        begin
            p_base  = (cur_radix == 6'd0) ? BASE_OCT : BASE_HEX;
            p_acc   = '0;
            p_conv  = 1'b1;
            p_stop  = 17'(p_pos) + 17'd1;
            p_phase = PH_ZERO;
            return;
        end
        p_base = (cur_radix == 6'd0) ? BASE_DEC : cur_radix;
        take_digit(c);
    endtask

    // Advance the model by one accepted byte; a NUL queues the owed result.
    task automatic parse_char(input logic [7:0] c);
        conversion_t r;
        bit          bad;
        if (c == CHAR_NUL)
        begin
            bad = p_phase == PH_INVALID ||
                  ((p_phase == PH_SPACE || p_phase == PH_START) && !radix_usable());
            if (bad)
            begin
                r = '{64'd0, ST_BAD_BASE, 16'd0};
            end
            else
            begin
                r.value      = p_neg ? -p_acc : p_acc;
                r.status     = p_ovf ? ST_RANGE : ST_OK;
                r.end_offset = p_conv ? p_stop[15:0] : 16'd0;
            end
            conversions_due.push_back(typed_pending ? typed_result : r);
            typed_pending = 1'b0;
            clear_string();
            return;
        end
        case (p_phase)
            PH_SPACE:
            begin
                if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF)
                begin
                    // skipped
                end
                else if (c == CHAR_PLUS || c == CHAR_MINUS)
                begin
                    if (!radix_usable())
                    begin
                        p_phase = PH_INVALID;
                    end
                    else
                    begin
                        p_neg   = c == CHAR_MINUS;
                        p_phase = PH_START;
                    end
                end
                else
                begin
                    begin_number(c);
                end
            end
            PH_START:
            begin
                begin_number(c);
            end
            PH_ZERO:
            begin
                if ((c == CHAR_X_LO || c == CHAR_X_UP) &&
                    (cur_radix == 6'd0 || cur_radix == BASE_HEX))
                begin
                    p_base  = BASE_HEX;
                    p_phase = PH_HEXPFX;
                end
                else
                begin
                    take_digit(c);
                end
            end
            PH_HEXPFX, PH_DIGITS:
            begin
                take_digit(c);
            end
            default:
            begin
                // done or invalid: bytes ignored up to the NUL
            end
        endcase
        if (p_pos != 16'hFFFF)
        begin
            p_pos = p_pos + 16'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Offer one byte, optionally after an idle burst; model it once taken.
    task automatic send_char(input logic [7:0] c);
        if (tx_idle_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        parse_char(c);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            send_char(s[k]);
        end
        send_char(CHAR_NUL);
    endtask

    task automatic send_buf();
        foreach (text_buf[k])
        begin
            send_char(text_buf[k]);
        end
    endtask

    // Stop offering, wait for every owed result, then let the pipe empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (conversions_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Both registers back to back; cfg_valid stays up between them.
    task automatic set_config(input logic [5:0] radix_val, input logic [63:0] limit_val);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RADIX;
        cfg_data  <= {junk[63:6], radix_val};   // upper bits are don't-care
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cur_radix = radix_val;
        cfg_index <= CFG_LIMIT;
        cfg_data  <= limit_val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cur_limit = limit_val;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random strings
    // ------------------------------------------------------------------------
    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10)
        begin
            return CHAR_ZERO + 8'(d);
        end
        return 8'(d - 10) + ($urandom_range(0, 1) ? 8'h61 : 8'h41);
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 3))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_CR;
            default: return CHAR_LF;
        endcase
    endfunction

    // Junk biased toward the bytes the parser cares about; never NUL.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 6))
            0:       return space_char();
            1:       return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
            2:       return CHAR_ZERO;
            3:       return $urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Mostly well-formed numbers with random content; some pure noise.
    // Some numbers sit right at the limit to hit the overflow boundary.
    task automatic make_string();
        int unsigned mode;
        int unsigned b;
        int unsigned n;
        logic [63:0] v;
        logic [7:0]  digits [$];
        text_buf.delete();
        b    = (radix_usable() && cur_radix >= 6'd2) ? int'(cur_radix) : 10;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            repeat ($urandom_range(0, 8)) text_buf.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 2)) text_buf.push_back(space_char());
            case ($urandom_range(0, 2))
                1:       text_buf.push_back(CHAR_PLUS);
                2:       text_buf.push_back(CHAR_MINUS);
                default: ;
            endcase
            if (cur_radix == 6'd0 || cur_radix == BASE_HEX)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        text_buf.push_back(CHAR_ZERO);
                        text_buf.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
                        b = 16;
                    end
                    1:
                    begin
                        if (cur_radix == 6'd0)
                        begin
                            text_buf.push_back(CHAR_ZERO);
                            b = 8;
                        end
                    end
                    default: ;
                endcase
            end
            if (mode == 2)
            begin
                v = cur_limit + 64'($urandom_range(0, 2)) - 64'd1;
                do
                begin
                    digits.push_front(digit_char(int'(v % 64'(b))));
                    v = v / 64'(b);
                end
                while (v != 0);
                foreach (digits[k])
                begin
                    text_buf.push_back(digits[k]);
                end
            end
            else
            begin
                n = (mode == 3) ? $urandom_range(10, 70) : $urandom_range(0, 8);
                repeat (n) text_buf.push_back(digit_char($urandom_range(0, b - 1)));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3)) text_buf.push_back(noise_byte());
            end
        end
        text_buf.push_back(CHAR_NUL);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result against the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (conversions_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result value %h status %0d end_offset %0d",
                         $time, value, status, end_offset);
            end
            else
            begin
                due = conversions_due.pop_front();
                if (value !== due.value)
                begin
                    mismatches++;
                    $display("%0t: value expected %h actual %h", $time, due.value, value);
                end
                if (status !== due.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, due.status, status);
                end
                if (end_offset !== due.end_offset)
                begin
                    mismatches++;
                    $display("%0t: end_offset expected %0d actual %0d",
                             $time, due.end_offset, end_offset);
                end
            end
        end
    end

    // Watchdog: any transfer on any channel resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results owed",
                         $time, conversions_due.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed strings. Typed results only where obvious; rest use the model.
    // ------------------------------------------------------------------------
    probe_t probes [NUM_PROBES] = '{
        // empty string right after reset
        '{6'd10, ALL_ONES, "",      1'b1, '{64'd0, ST_OK, 16'd0}},
        // leading space, minus sign: two's complement
        '{6'd10, ALL_ONES, " -12",  1'b1, '{64'hFFFF_FFFF_FFFF_FFF4, ST_OK, 16'd4}},
        // auto base, hex prefix
        '{6'd0,  ALL_ONES, "0x1F",  1'b0, '{64'd0, ST_OK, 16'd0}},
        // lone zero prefix: "0x" then non-hex
        '{6'd16, ALL_ONES, "0xg",   1'b0, '{64'd0, ST_OK, 16'd0}},
        // auto base, octal from leading zero
        '{6'd0,  ALL_ONES, "017",   1'b0, '{64'd0, ST_OK, 16'd0}},
        // sign without digits, top radix
        '{6'd36, ALL_ONES, "+",     1'b1, '{64'd0, ST_OK, 16'd0}},
        // first digit already past a tiny limit
        '{6'd10, 64'd8,    "9",     1'b1, '{ALL_ONES, ST_RANGE, 16'd1}},
        // radix 1 is invalid
        '{6'd1,  ALL_ONES, "5",     1'b1, '{64'd0, ST_BAD_BASE, 16'd0}},
        // whitespace only with the highest invalid radix
        '{6'd63, ALL_ONES, "\t",    1'b1, '{64'd0, ST_BAD_BASE, 16'd0}},
        // non-ASCII byte is never a digit
        '{6'd2,  ALL_ONES, "\377",  1'b1, '{64'd0, ST_OK, 16'd0}}
    };

    logic [5:0] phase_radix [NUM_PHASES] = '{6'd10, 6'd0, 6'd2, 6'd36, 6'd16,
                                             6'd0, 6'd1, 6'd37, 6'd8, 6'd10};

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          phase_bytes;
        logic [63:0] lim;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_in       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_RADIX;
        cfg_data      = '0;
        out_stall     = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_req      = 1'b0;
        typed_pending = 1'b0;
        cur_radix     = RADIX_RESET;
        cur_limit     = ALL_ONES;
        clear_string();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; registers change only between strings, when drained
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            if (i == 0 || probes[i].radix != cur_radix || probes[i].limit != cur_limit)
            begin
                settle();
                set_config(probes[i].radix, probes[i].limit);
            end
            typed_pending = probes[i].typed;
            typed_result  = probes[i].result;
            send_text(probes[i].text);
        end

        // a long run of leading zeros ahead of the last digit
        settle();
        set_config(BASE_DEC, ALL_ONES);
        repeat (LONG_ZEROS) send_char(CHAR_ZERO);
        send_char(CHAR_ZERO + 8'd7);
        send_char(CHAR_NUL);

        // random strings under a series of settings, extremes included
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                2:       lim = 64'd1;
                4, 7:    lim = {$urandom, $urandom};
                5:       lim = 64'($urandom_range(1, 5000));
                8:       lim = {$urandom, $urandom} >> $urandom_range(0, 60);
                default: lim = ALL_ONES;
            endcase
            if (lim == 64'd0)
            begin
                lim = 64'd1;
            end
            settle();
            set_config(phase_radix[p], lim);
            if (p == 1)
            begin
                hold_req = 1'b1;   // sender keeps offering; block must back up
            end
            if (p == NUM_PHASES - 1)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                make_string();
                phase_bytes += text_buf.size();
                send_buf();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/atoi_pkg.sv
rtl/core/ascii_to_integer_parser.sv
test/ascii_to_integer_parser_test.sv
